FILE: rtl/sfbp_pkg.sv
// Shared constants and types for the sonar frame byte parser.
package sfbp_pkg;

  localparam int PHASE_W = 4;
  localparam int LEN_W   = 16;

  localparam logic [7:0] START_BYTE  = 8'h42;  // 'B'
  localparam logic [7:0] HEADER_BYTE = 8'h52;  // 'R'

  localparam logic [PHASE_W-1:0] PH_START   = 4'd0;
  localparam logic [PHASE_W-1:0] PH_HEADER  = 4'd1;
  localparam logic [PHASE_W-1:0] PH_LEN_L   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_LEN_H   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_ID_L    = 4'd4;
  localparam logic [PHASE_W-1:0] PH_ID_H    = 4'd5;
  localparam logic [PHASE_W-1:0] PH_SRC     = 4'd6;
  localparam logic [PHASE_W-1:0] PH_DST     = 4'd7;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd8;
  localparam logic [PHASE_W-1:0] PH_CK_L    = 4'd9;
  localparam logic [PHASE_W-1:0] PH_CK_H    = 4'd10;

  typedef struct packed {
    logic [PHASE_W-1:0] parse_phase;
    logic               payload_valid;
    logic [7:0]         payload_data;
    logic               frame_done;
    logic [15:0]        frame_msg_id;
    logic [LEN_W-1:0]   frame_length;
    logic [7:0]         frame_source;
    logic [7:0]         frame_dest;
    logic [15:0]        frame_checksum;
  } sfbp_result_t;

endpackage

FILE: rtl/sfbp_if.sv
// Valid/ready channel interfaces for received bytes and parse results.
interface sfbp_byte_if ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfbp_result_if import sfbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] parse_phase;
  logic               payload_valid;
  logic [7:0]         payload_data;
  logic               frame_done;
  logic [15:0]        frame_msg_id;
  logic [LEN_W-1:0]   frame_length;
  logic [7:0]         frame_source;
  logic [7:0]         frame_dest;
  logic [15:0]        frame_checksum;

  modport source (
    output valid, input ready,
    output parse_phase, output payload_valid, output payload_data, output frame_done,
    output frame_msg_id, output frame_length, output frame_source, output frame_dest,
    output frame_checksum
  );
  modport sink (
    input valid, output ready,
    input parse_phase, input payload_valid, input payload_data, input frame_done,
    input frame_msg_id, input frame_length, input frame_source, input frame_dest,
    input frame_checksum
  );
endinterface

FILE: rtl/sfbp_fsm.sv
// Framing state machine: header field capture and per-byte result decode.
module sfbp_fsm import sfbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   rx_byte,
  output sfbp_result_t result
);

  logic [PHASE_W-1:0] phase, phase_next;
  logic [LEN_W-1:0]   bytes_left, bytes_left_next;
  logic [LEN_W-1:0]   declared_length;
  logic [15:0]        msg_ident;
  logic [7:0]         source_id;
  logic [7:0]         dest_id;
  logic [7:0]         checksum_low;

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    result          = '0;
    unique case (phase)
      PH_START: begin
        if (rx_byte == START_BYTE) phase_next = PH_HEADER;
      end
      PH_HEADER: begin
        // a wrong second byte is dropped, not retried as a start byte
        phase_next = (rx_byte == HEADER_BYTE) ? PH_LEN_L : PH_START;
      end
      PH_LEN_L: phase_next = PH_LEN_H;
      PH_LEN_H: begin
        bytes_left_next = {rx_byte, declared_length[7:0]};
        phase_next      = PH_ID_L;
      end
      PH_ID_L: phase_next = PH_ID_H;
      PH_ID_H: phase_next = PH_SRC;
      PH_SRC:  phase_next = PH_DST;
      PH_DST: begin
        phase_next = (bytes_left == '0) ? PH_CK_L : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        result.payload_valid = 1'b1;
        result.payload_data  = rx_byte;
        bytes_left_next      = bytes_left - LEN_W'(1);
        if (bytes_left == LEN_W'(1)) phase_next = PH_CK_L;
      end
      PH_CK_L: phase_next = PH_CK_H;
      PH_CK_H: begin
        result.frame_done     = 1'b1;
        result.frame_msg_id   = msg_ident;
        result.frame_length   = declared_length;
        result.frame_source   = source_id;
        result.frame_dest     = dest_id;
        result.frame_checksum = {rx_byte, checksum_low};
        phase_next            = PH_START;
      end
      default: phase_next = PH_START;
    endcase
    result.parse_phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      bytes_left <= '0;
    end else if (take) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

  // header fields are always rewritten before a frame can complete
  always_ff @(posedge clk) begin
    if (take) begin
      if (phase == PH_LEN_L) declared_length[7:0]  <= rx_byte;
      if (phase == PH_LEN_H) declared_length[15:8] <= rx_byte;
      if (phase == PH_ID_L)  msg_ident[7:0]        <= rx_byte;
      if (phase == PH_ID_H)  msg_ident[15:8]       <= rx_byte;
      if (phase == PH_SRC)   source_id             <= rx_byte;
      if (phase == PH_DST)   dest_id               <= rx_byte;
      if (phase == PH_CK_L)  checksum_low          <= rx_byte;
    end
  end

endmodule

FILE: rtl/sfbp_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module sfbp_out_reg import sfbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  sfbp_result_t load_data,
  input  logic         out_ready,
  output logic         out_valid,
  output sfbp_result_t out_data,
  output logic         can_load
);

  // a new beat may enter in the same cycle the held one leaves
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) out_data <= load_data;
  end

endmodule

FILE: rtl/sonar_frame_byte_parser_unit.sv
// Top level of the sonar frame byte parser.
// Parses a sonar link frame ('B', 'R', length, message id, source, destination,
// payload, checksum) one byte per beat. Every accepted byte gives exactly one
// result beat in the following cycle, carrying the phase after that byte, the byte
// itself when it was payload, and the header fields plus the received checksum
// on the last checksum byte. A byte is accepted every cycle while the result
// register is empty or being drained; the state update and result decode sit
// in one short stage between the input handshake and the result register.
// The checksum is reported but not verified.
module sonar_frame_byte_parser_unit import sfbp_pkg::*; (
  input logic         clk,
  input logic         rst,
  sfbp_byte_if.sink   rx,
  sfbp_result_if.source res
);

  sfbp_result_t fsm_result;
  sfbp_result_t held;
  logic         can_load;
  logic         take;

  assign rx.ready = can_load;
  assign take     = rx.valid && can_load;

  sfbp_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .result  (fsm_result)
  );

  sfbp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_data (fsm_result),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .out_data  (held),
    .can_load  (can_load)
  );

  assign res.parse_phase    = held.parse_phase;
  assign res.payload_valid  = held.payload_valid;
  assign res.payload_data   = held.payload_data;
  assign res.frame_done     = held.frame_done;
  assign res.frame_msg_id   = held.frame_msg_id;
  assign res.frame_length   = held.frame_length;
  assign res.frame_source   = held.frame_source;
  assign res.frame_dest     = held.frame_dest;
  assign res.frame_checksum = held.frame_checksum;

`ifndef ASSERT_OFF
  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready |=> res.valid)
    else $error("accepted byte produced no result beat");

  a_done_ends_frame: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.frame_done |-> res.parse_phase == PH_START && !res.payload_valid)
    else $error("frame completion not back at start phase");

  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.payload_valid |->
      res.parse_phase == PH_PAYLOAD || res.parse_phase == PH_CK_L)
    else $error("payload byte reported outside payload phases");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |-> !rx.ready)
    else $error("input ready while result register is stalled");
`endif

endmodule
